FILE: src/fic_pkg.sv
// ----------------------------------------------------------------------------
// fic_pkg
// Shared types and constants for the floppy interface controller.
// ----------------------------------------------------------------------------
package fic_pkg;

  localparam int SECTOR_BYTES = 128;
  localparam int PACKED_BYTES = (SECTOR_BYTES * 3) / 4;
  localparam int BUF_AW       = $clog2(SECTOR_BYTES);

  // flag bit positions
  localparam int FL_TR   = 0;
  localparam int FL_ERR  = 1;
  localparam int FL_DONE = 2;
  localparam int FL_IE   = 3;

  // I/O instruction codes
  localparam logic [2:0] IOT_NOP   = 3'd0;
  localparam logic [2:0] IOT_LCD   = 3'd1;
  localparam logic [2:0] IOT_XDR   = 3'd2;
  localparam logic [2:0] IOT_STR   = 3'd3;
  localparam logic [2:0] IOT_SER   = 3'd4;
  localparam logic [2:0] IOT_SDN   = 3'd5;
  localparam logic [2:0] IOT_INTR  = 3'd6;
  localparam logic [2:0] IOT_INIT  = 3'd7;

  // command functions
  localparam logic [2:0] FN_FILL   = 3'd0;
  localparam logic [2:0] FN_EMPTY  = 3'd1;
  localparam logic [2:0] FN_WRITE  = 3'd2;
  localparam logic [2:0] FN_READ   = 3'd3;
  localparam logic [2:0] FN_INITS  = 3'd4;
  localparam logic [2:0] FN_RDSTAT = 3'd5;
  localparam logic [2:0] FN_WRDEL  = 3'd6;
  localparam logic [2:0] FN_RDERR  = 3'd7;

  // pending drive operation
  localparam logic [2:0] PEND_IDLE  = 3'd0;
  localparam logic [2:0] PEND_READ  = 3'd1;
  localparam logic [2:0] PEND_WRITE = 3'd2;
  localparam logic [2:0] PEND_WRDEL = 3'd3;
  localparam logic [2:0] PEND_STAT  = 3'd4;

  // error values
  localparam logic [6:0] ERR_NOMEDIA = 7'o110;
  localparam logic [6:0] ERR_WRFAIL  = 7'o140;
  localparam logic [6:0] ERR_SECTOR  = 7'o070;
  localparam logic [6:0] ERR_TRACK   = 7'o040;

  // status masks
  localparam logic [11:0] ST_KEEP_XFER = 12'o7676;
  localparam logic [11:0] ST_KEEP_INIT = 12'o0303;
  localparam logic [11:0] ST_DRDY      = 12'o0200;

  typedef struct packed {
    logic        action;
    logic [2:0]  iot_op;
    logic [11:0] ac_in;
    logic        media_present;
    logic        deleted_mark;
    logic        crc_fail;
    logic        write_fail;
  } fic_in_t;

  typedef struct packed {
    logic [11:0] ac_out;
    logic        skip;
    logic        irq_level;
    logic        drive_request;
    logic [1:0]  drive_op;
    logic        drive_unit;
    logic [6:0]  drive_track;
    logic [4:0]  drive_sector;
  } fic_out_t;

  typedef enum logic [2:0] {
    K_NONE, K_E8, K_E12, K_F8, K_F12
  } kind_t;

  typedef enum logic [3:0] {
    U_IDLE, U_EXEC, U_RD_A, U_RD_B, U_E8, U_E12, U_F8, U_HI, U_OR,
    U_LO0, U_LO1, U_PAD_RD, U_PAD_WR
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_t exec_kind;
    kind_t kind;
    logic  half;
    logic  pad;
    logic  pad_last;
  } stat_t;

endpackage

FILE: src/fic_datapath.sv
// ----------------------------------------------------------------------------
// fic_datapath
// Card registers, flags, sector buffer and the per-request update logic.
// ----------------------------------------------------------------------------
module fic_datapath #(
  parameter int LAST_TRACK  = 76,
  parameter int LAST_SECTOR = 26
) (
  input  logic             clk,
  input  logic             rst_n,
  input  fic_pkg::fic_in_t in_data,
  input  fic_pkg::cmd_t    cmd,
  output fic_pkg::stat_t   stat,
  output fic_pkg::fic_out_t out_data
);
  import fic_pkg::*;

  fic_in_t      it_r;
  logic [7:0]   cmd_r, cmd_nxt;
  logic [11:0]  ir_r, ir_nxt;
  logic [6:0]   err_r, err_nxt;
  logic [7:0]   trk_r, trk_nxt;
  logic [6:0]   sec_r, sec_nxt;
  logic [11:0]  st_r, st_nxt;
  logic [7:0]   pos_r, pos_nxt;
  logic         half_r, half_nxt;
  logic [3:0]   fl_r, fl_nxt;
  logic [2:0]   pend_r, pend_nxt;
  logic [11:0]  ac_r, ac_nxt;
  logic         skip_r, skip_nxt;
  logic         req_r, req_nxt;
  kind_t        kind_r, kind_c;
  logic [7:0]   a_r, rd_q, cnt_r, cnt_nxt;
  fic_out_t     out_q;

  logic [7:0]   mem [SECTOR_BYTES];
  logic         we, re;
  logic [BUF_AW-1:0] wa, ra;
  logic [7:0]   wd;

  always_comb begin
    logic       m, e;
    logic [2:0] f;
    logic [7:0] pinc;
    cmd_nxt = cmd_r; ir_nxt = ir_r; err_nxt = err_r; trk_nxt = trk_r;
    sec_nxt = sec_r; st_nxt = st_r; pos_nxt = pos_r; half_nxt = half_r;
    fl_nxt = fl_r; pend_nxt = pend_r; ac_nxt = ac_r; skip_nxt = skip_r;
    req_nxt = req_r; cnt_nxt = cnt_r; kind_c = K_NONE;
    we = 1'b0; re = 1'b0; wa = pos_r[BUF_AW-1:0]; ra = pos_r[BUF_AW-1:0]; wd = '0;
    m = cmd_r[7]; e = cmd_r[6]; f = cmd_r[3:1];
    pinc = pos_r + 8'd1;
    unique case (cmd.uop)
      U_IDLE: ;
      U_EXEC: begin
        ac_nxt = it_r.ac_in; skip_nxt = 1'b0; req_nxt = 1'b0;
        if (it_r.action) begin
          if (pend_r >= PEND_READ && pend_r <= PEND_STAT) begin
            if (!it_r.media_present) begin
              err_nxt = ERR_NOMEDIA; fl_nxt[FL_ERR] = 1'b1;
            end else if (pend_r == PEND_STAT) begin
              st_nxt = (st_r | ST_DRDY) & ST_KEEP_INIT;
            end else if (pend_r == PEND_READ) begin
              st_nxt = st_r & ST_KEEP_XFER;
              if (it_r.crc_fail) begin
                fl_nxt[FL_ERR] = 1'b1; st_nxt[0] = 1'b1;
              end else st_nxt[6] = it_r.deleted_mark;
            end else begin
              st_nxt = st_r & ST_KEEP_XFER;
              if (it_r.write_fail) begin
                err_nxt = ERR_WRFAIL; fl_nxt[FL_ERR] = 1'b1;
              end else st_nxt[6] = (pend_r == PEND_WRDEL);
            end
            fl_nxt[FL_DONE] = 1'b1; pend_nxt = PEND_IDLE; ir_nxt = st_nxt;
          end
        end else begin
          unique case (it_r.iot_op)
            IOT_NOP: ;
            IOT_LCD: begin
              cmd_nxt = it_r.ac_in[7:0]; ac_nxt = '0;
              m = it_r.ac_in[7]; e = it_r.ac_in[6]; f = it_r.ac_in[3:1];
              if (m) fl_nxt[FL_DONE:FL_TR] = 3'b111;
              else begin
                unique case (f)
                  FN_EMPTY: begin
                    if (e ? (pos_r < 8'(SECTOR_BYTES)) : (pos_r < 8'(PACKED_BYTES)))
                      kind_c = e ? K_E8 : K_E12;
                    else begin
                      fl_nxt[FL_DONE] = 1'b1; half_nxt = 1'b0; pos_nxt = '0; ir_nxt = st_r;
                    end
                  end
                  FN_INITS: begin
                    st_nxt = st_r & ST_KEEP_INIT;
                    fl_nxt[FL_DONE] = 1'b1; half_nxt = 1'b0; pos_nxt = '0; ir_nxt = st_nxt;
                  end
                  FN_RDSTAT: begin pend_nxt = PEND_STAT; req_nxt = 1'b1; end
                  FN_RDERR: begin
                    fl_nxt[FL_DONE] = 1'b1; half_nxt = 1'b0; pos_nxt = '0;
                    ir_nxt = {5'd0, err_r};
                  end
                  FN_FILL, FN_WRITE, FN_READ, FN_WRDEL: begin
                    half_nxt = 1'b0; fl_nxt[FL_TR] = 1'b1;
                  end
                endcase
              end
            end
            IOT_XDR: begin
              if (m) ac_nxt = it_r.ac_in | ir_r;
              else begin
                unique case (f)
                  FN_FILL: begin ir_nxt = it_r.ac_in; kind_c = e ? K_F8 : K_F12; end
                  FN_EMPTY: begin
                    ac_nxt = e ? (it_r.ac_in | ir_r) : ir_r;
                    if (e ? (pos_r < 8'(SECTOR_BYTES)) : (pos_r < 8'(PACKED_BYTES)))
                      kind_c = e ? K_E8 : K_E12;
                    else begin
                      fl_nxt[FL_DONE] = 1'b1; half_nxt = 1'b0; pos_nxt = '0; ir_nxt = st_r;
                    end
                  end
                  FN_WRITE, FN_READ, FN_WRDEL: begin
                    ir_nxt = it_r.ac_in;
                    if (!half_r) begin
                      sec_nxt = it_r.ac_in[6:0]; fl_nxt[FL_TR] = 1'b1; half_nxt = 1'b1;
                    end else begin
                      pos_nxt = '0; half_nxt = 1'b0; trk_nxt = it_r.ac_in[7:0];
                      if (trk_nxt > 8'(LAST_TRACK)) begin
                        err_nxt = ERR_TRACK; fl_nxt[FL_ERR] = 1'b1;
                        fl_nxt[FL_DONE] = 1'b1; ir_nxt = st_r;
                      end else if (sec_r == '0 || sec_r > 7'(LAST_SECTOR)) begin
                        err_nxt = ERR_SECTOR; fl_nxt[FL_ERR] = 1'b1;
                        fl_nxt[FL_DONE] = 1'b1; ir_nxt = st_r;
                      end else begin
                        req_nxt = 1'b1;
                        pend_nxt = (f == FN_WRITE) ? PEND_WRITE :
                                   (f == FN_READ) ? PEND_READ : PEND_WRDEL;
                      end
                    end
                  end
                  FN_INITS, FN_RDSTAT, FN_RDERR: ac_nxt = it_r.ac_in | ir_r;
                endcase
              end
            end
            IOT_STR: begin skip_nxt = fl_r[FL_TR]; if (!m) fl_nxt[FL_TR] = 1'b0; end
            IOT_SER: begin skip_nxt = fl_r[FL_ERR]; if (!m) fl_nxt[FL_ERR] = 1'b0; end
            IOT_SDN: begin skip_nxt = fl_r[FL_DONE]; if (!m) fl_nxt[FL_DONE] = 1'b0; end
            IOT_INTR: fl_nxt[FL_IE] = it_r.ac_in[0];
            IOT_INIT: begin
              ir_nxt = '0; err_nxt = '0; st_nxt = '0; cmd_nxt = '0; trk_nxt = 8'd1;
              sec_nxt = 7'd1; fl_nxt = '0; pend_nxt = PEND_READ; pos_nxt = '0;
              half_nxt = 1'b0; req_nxt = 1'b1;
            end
          endcase
        end
      end
      U_RD_A: re = 1'b1;
      U_RD_B: begin re = 1'b1; ra = pinc[BUF_AW-1:0]; end
      U_E8: begin ir_nxt = {4'd0, rd_q}; pos_nxt = pinc; fl_nxt[FL_TR] = 1'b1; end
      U_E12: begin
        if (!half_r) begin
          ir_nxt = {a_r, rd_q[7:4]}; pos_nxt = pinc; half_nxt = 1'b1;
        end else begin
          ir_nxt = {a_r[3:0], rd_q}; pos_nxt = pos_r + 8'd2; half_nxt = 1'b0;
        end
        fl_nxt[FL_TR] = 1'b1;
      end
      U_F8: begin
        we = 1'b1; wd = ir_r[7:0]; pos_nxt = pinc;
        if (pinc >= 8'(SECTOR_BYTES)) begin
          fl_nxt[FL_DONE] = 1'b1; half_nxt = 1'b0; pos_nxt = '0; ir_nxt = st_r;
        end else fl_nxt[FL_TR] = 1'b1;
      end
      U_HI: begin we = 1'b1; wd = ir_r[11:4]; end
      U_OR: begin we = 1'b1; wd = rd_q | {4'd0, ir_r[11:8]}; end
      U_LO0: begin
        we = 1'b1; wa = pinc[BUF_AW-1:0]; wd = {ir_r[3:0], 4'd0};
        pos_nxt = pinc; half_nxt = 1'b1;
        if (pos_nxt < 8'(PACKED_BYTES)) fl_nxt[FL_TR] = 1'b1;
      end
      U_LO1: begin
        we = 1'b1; wa = pinc[BUF_AW-1:0]; wd = ir_r[7:0];
        pos_nxt = pos_r + 8'd2; half_nxt = 1'b0;
        if (pos_nxt < 8'(PACKED_BYTES)) fl_nxt[FL_TR] = 1'b1;
      end
      U_PAD_RD: begin
        re = pos_r >= 8'(PACKED_BYTES); ra = BUF_AW'(PACKED_BYTES); cnt_nxt = pos_r;
      end
      U_PAD_WR: begin
        we = !cnt_r[BUF_AW]; wa = cnt_r[BUF_AW-1:0]; wd = rd_q; cnt_nxt = cnt_r + 8'd1;
        if (cnt_r >= 8'(SECTOR_BYTES - 1)) begin
          fl_nxt[FL_DONE] = 1'b1; half_nxt = 1'b0; pos_nxt = '0; ir_nxt = st_r;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= '0; ir_r <= '0; err_r <= '0; trk_r <= 8'd1; sec_r <= 7'd1;
      st_r <= '0; pos_r <= '0; half_r <= 1'b0; fl_r <= '0; pend_r <= PEND_IDLE;
    end else begin
      cmd_r <= cmd_nxt; ir_r <= ir_nxt; err_r <= err_nxt; trk_r <= trk_nxt;
      sec_r <= sec_nxt; st_r <= st_nxt; pos_r <= pos_nxt; half_r <= half_nxt;
      fl_r <= fl_nxt; pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) it_r <= in_data;
    if (cmd.uop == U_EXEC) kind_r <= kind_c;
    if (cmd.uop == U_RD_B) a_r <= rd_q;
    ac_r <= ac_nxt; skip_r <= skip_nxt; req_r <= req_nxt; cnt_r <= cnt_nxt;
    if (cmd.out_load) begin
      out_q.ac_out        <= ac_r;
      out_q.skip          <= skip_r;
      out_q.irq_level     <= fl_r[FL_DONE] & fl_r[FL_IE];
      out_q.drive_request <= req_r;
      out_q.drive_op      <= req_r ? 2'(pend_r - 3'd1) : 2'd0;
      out_q.drive_unit    <= req_r & cmd_r[4];
      out_q.drive_track   <= req_r ? trk_r[6:0] : 7'd0;
      out_q.drive_sector  <= req_r ? sec_r[4:0] : 5'd0;
    end
  end

  assign out_data       = out_q;
  assign stat.exec_kind = kind_c;
  assign stat.kind      = kind_r;
  assign stat.half      = half_r;
  assign stat.pad       = pos_r >= 8'(PACKED_BYTES);
  assign stat.pad_last  = cnt_r >= 8'(SECTOR_BYTES - 1);

endmodule

FILE: src/fic_ctrl.sv
// ----------------------------------------------------------------------------
// fic_ctrl
// Sequencer: steps the datapath through one request and owns the handshakes.
// ----------------------------------------------------------------------------
module fic_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  fic_pkg::stat_t stat,
  output fic_pkg::cmd_t  cmd
);
  import fic_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001, S_EXEC  = 14'b00000000000010,
    S_RDA   = 14'b00000000000100, S_RDB   = 14'b00000000001000,
    S_E8    = 14'b00000000010000, S_E12   = 14'b00000000100000,
    S_F8    = 14'b00000001000000, S_HI    = 14'b00000010000000,
    S_OR    = 14'b00000100000000, S_LO0   = 14'b00001000000000,
    S_LO1   = 14'b00010000000000, S_PADRD = 14'b00100000000000,
    S_PADWR = 14'b01000000000000, S_DONE  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   free;

  assign free     = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.uop      = U_IDLE;
    cmd.load     = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.uop = U_EXEC;
        unique case (stat.exec_kind)
          K_NONE: state_nxt = S_DONE;
          K_E8, K_E12: state_nxt = S_RDA;
          K_F8: state_nxt = S_F8;
          K_F12: state_nxt = stat.half ? S_RDA : S_HI;
          default: state_nxt = S_DONE;
        endcase
      end
      S_RDA: begin
        cmd.uop = U_RD_A;
        priority if (stat.kind == K_E8) state_nxt = S_E8;
        else if (stat.kind == K_E12) state_nxt = S_RDB;
        else state_nxt = S_OR;
      end
      S_RDB:   begin cmd.uop = U_RD_B; state_nxt = S_E12; end
      S_E8:    begin cmd.uop = U_E8;   state_nxt = S_DONE; end
      S_E12:   begin cmd.uop = U_E12;  state_nxt = S_DONE; end
      S_F8:    begin cmd.uop = U_F8;   state_nxt = S_DONE; end
      S_HI:    begin cmd.uop = U_HI;   state_nxt = S_LO0; end
      S_OR:    begin cmd.uop = U_OR;   state_nxt = S_LO1; end
      S_LO0:   begin cmd.uop = U_LO0;  state_nxt = S_PADRD; end
      S_LO1:   begin cmd.uop = U_LO1;  state_nxt = S_PADRD; end
      S_PADRD: begin
        cmd.uop = U_PAD_RD;
        state_nxt = stat.pad ? S_PADWR : S_DONE;
      end
      S_PADWR: begin
        cmd.uop = U_PAD_WR;
        if (stat.pad_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state register not one-hot");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_EXEC)
    else $error("accepted request did not start");
  a_post: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && free |=> out_valid_r && state_r == S_IDLE)
    else $error("result not posted");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PADWR |-> $past(state_r) == S_PADRD || $past(state_r) == S_PADWR)
    else $error("pad write without pad read");
`endif

endmodule

FILE: src/floppy_interface_controller.sv
// ----------------------------------------------------------------------------
// floppy_interface_controller
// Floppy interface card: I/O instructions and drive completions in, one
// result per request out.
// ----------------------------------------------------------------------------
// Usage:
//  - in_valid/in_ready carry one request: an I/O instruction with the
//    accumulator, or a completion of the pending drive operation.
//  - out_valid/out_ready return exactly one result per request: new
//    accumulator, skip, interrupt level and any new drive request.
//  - Steps: a register-only request runs EXEC then DONE. Buffer empty
//    adds RDA and E8 (8-bit) or RDA, RDB and E12 (12-bit); 8-bit fill adds F8;
//    12-bit fill adds HI and LO0, or RDA, OR and LO1, then PADRD. A
//    12-bit fill that reaches byte 96 pads the rest of the sector buffer
//    one byte a cycle. One request is in work at a time.
//  - A request may be accepted while the previous result still waits; the
//    sequencer holds before posting its own result until the slot frees,
//    so a stalled receiver back-pressures after one request.
//  - Reset clears card registers and flags (track, sector to 1); the sector
//    buffer holds garbage until written and needs no clearing pass.
// ----------------------------------------------------------------------------
module floppy_interface_controller #(
  parameter int LAST_TRACK  = 76,
  parameter int LAST_SECTOR = 26
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fic_pkg::fic_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fic_pkg::fic_out_t out_data
);
  import fic_pkg::*;

  cmd_t  cmd;   // sequencer -> datapath
  stat_t stat;  // datapath -> sequencer

  fic_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fic_datapath #(
    .LAST_TRACK  (LAST_TRACK),
    .LAST_SECTOR (LAST_SECTOR)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
